[rtl/nmea_rmc_checksum_time_extract_defines.svh]
// assertion macros for the nmea rmc checksum and time extractor
// used by the top level; no other dependencies
`ifndef NMEA_RMC_CHECKSUM_TIME_EXTRACT_DEFINES_SVH
`define NMEA_RMC_CHECKSUM_TIME_EXTRACT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NRMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define NRMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/nrmc_pkg.sv]
// shared types, character codes and helper functions for the nmea rmc extractor
// no dependencies
package nrmc_pkg;

   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_F   = 8'h46;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;

   localparam logic [2:0] PREFIX_LAST = 3'd6;   // position of the ',' in "$GPRMC,"
   localparam logic [2:0] TIME_LAST   = 3'd5;   // index of the last time digit
   localparam logic [4:0] ZONE_RESET  = 5'd8;

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_TIME,
      PH_BODY,
      PH_HEX,
      PH_TAIL,
      PH_DISCARD
   } phase_type;

   // what the parser reports for the word it is looking at
   typedef struct packed {
      logic            emit;      // newline that closes a qualifying line
      logic            sum_bad;   // running xor differs from received checksum
      logic [5:0][3:0] digits;    // hhmmss, digit 0 first
   } line_end_type;

   // expected character at each prefix position
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = 8'h24;   // $
         3'd1: c = 8'h47;   // G
         3'd2: c = 8'h50;   // P
         3'd3: c = 8'h52;   // R
         3'd4: c = 8'h4D;   // M
         3'd5: c = 8'h43;   // C
         3'd6: c = 8'h2C;   // ,
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= CHAR_UC_A && c <= CHAR_UC_F) || (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

   // two bcd digits to binary, 0..99
   function automatic logic [6:0] bcd_pair(input logic [3:0] tens, input logic [3:0] ones);
      return {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
   endfunction

   // x mod 24 for x up to 191
   function automatic logic [4:0] mod24(input logic [7:0] x);
      logic [7:0] r;
      r = x;
      if (r >= 8'd96) begin
         r = r - 8'd96;
      end
      if (r >= 8'd48) begin
         r = r - 8'd48;
      end
      if (r >= 8'd24) begin
         r = r - 8'd24;
      end
      return r[4:0];
   endfunction

endpackage

[rtl/nrmc_parse.sv]
// line parser: prefix match, time digit capture, running xor, hex checksum
// depends on nrmc_pkg
module nrmc_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            byte_in,
   input  logic                  advance,
   output nrmc_pkg::line_end_type line_end
);
   import nrmc_pkg::*;

   phase_type       phase_ff, phase_in;
   logic [2:0]      prefix_pos_ff, prefix_pos_in;
   logic [7:0]      xor_ff, xor_in;
   logic [2:0]      digit_cnt_ff, digit_cnt_in;
   logic [7:0]      cksum_ff, cksum_in;
   logic            hex_cnt_ff, hex_cnt_in;
   logic [5:0][3:0] digit_ff, digit_in;
   logic [4:0]      hex_v;

   always_comb begin
      phase_in      = phase_ff;
      prefix_pos_in = prefix_pos_ff;
      xor_in        = xor_ff;
      digit_cnt_in  = digit_cnt_ff;
      cksum_in      = cksum_ff;
      hex_cnt_in    = hex_cnt_ff;
      digit_in      = digit_ff;
      hex_v         = hex_value(byte_in);

      if (byte_in == CHAR_LF) begin
         phase_in      = PH_PREFIX;
         prefix_pos_in = 3'd0;
         xor_in        = 8'h00;
         digit_cnt_in  = 3'd0;
         cksum_in      = 8'h00;
         hex_cnt_in    = 1'b0;
      end else begin
         case (phase_ff)
            PH_PREFIX: begin
               if (byte_in != prefix_char(prefix_pos_ff)) begin
                  phase_in = PH_DISCARD;
               end else begin
                  // '$' itself is not covered by the checksum
                  if (prefix_pos_ff != 3'd0) begin
                     xor_in = xor_ff ^ byte_in;
                  end
                  prefix_pos_in = prefix_pos_ff + 3'd1;
                  if (prefix_pos_ff == PREFIX_LAST) begin
                     phase_in = PH_TIME;
                  end
               end
            end
            PH_TIME: begin
               if (byte_in < CHAR_ZERO || byte_in > CHAR_NINE) begin
                  phase_in = PH_DISCARD;
               end else begin
                  xor_in                 = xor_ff ^ byte_in;
                  digit_in[digit_cnt_ff] = byte_in[3:0];
                  digit_cnt_in           = digit_cnt_ff + 3'd1;
                  if (digit_cnt_ff == TIME_LAST) begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (byte_in == CHAR_STAR) begin
                  phase_in = PH_HEX;
               end else begin
                  xor_in = xor_ff ^ byte_in;
               end
            end
            PH_HEX: begin
               if (!hex_v[4]) begin
                  cksum_in   = {cksum_ff[3:0], hex_v[3:0]};
                  hex_cnt_in = 1'b1;
                  if (hex_cnt_ff) begin
                     phase_in = PH_TAIL;
                  end
               end else begin
                  phase_in = PH_TAIL;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREFIX;
         prefix_pos_ff <= 3'd0;
         xor_ff        <= 8'h00;
         digit_cnt_ff  <= 3'd0;
         cksum_ff      <= 8'h00;
         hex_cnt_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         prefix_pos_ff <= prefix_pos_in;
         xor_ff        <= xor_in;
         digit_cnt_ff  <= digit_cnt_in;
         cksum_ff      <= cksum_in;
         hex_cnt_ff    <= hex_cnt_in;
      end
   end

   // all six digits are written before any line can emit
   always_ff @(posedge clock) begin
      if (advance) begin
         digit_ff <= digit_in;
      end
   end

   assign line_end.emit    = (byte_in == CHAR_LF) && (phase_ff == PH_HEX || phase_ff == PH_TAIL);
   assign line_end.sum_bad = (xor_ff != cksum_ff);
   assign line_end.digits  = digit_ff;

endmodule

[rtl/nrmc_out.sv]
// result register: local time formatting and response handshake
// depends on nrmc_pkg
module nrmc_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  nrmc_pkg::line_end_type line_end,
   input  logic [4:0]            zone_offset,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_status,
   output logic [4:0]            rsp_hour_out,
   output logic [6:0]            rsp_minute_out,
   output logic [6:0]            rsp_second_out
);
   import nrmc_pkg::*;

   logic       valid_ff, valid_in;
   logic       status_ff, status_in;
   logic [4:0] hour_ff, hour_in;
   logic [6:0] minute_ff, minute_in;
   logic [6:0] second_ff, second_in;
   logic [6:0] hh;

   always_comb begin
      hh = bcd_pair(line_end.digits[0], line_end.digits[1]);
      if (line_end.sum_bad) begin
         status_in = 1'b1;
         hour_in   = 5'd0;
         minute_in = 7'd0;
         second_in = 7'd0;
      end else begin
         status_in = 1'b0;
         hour_in   = mod24({1'b0, hh} + {3'b000, zone_offset});
         minute_in = bcd_pair(line_end.digits[2], line_end.digits[3]);
         second_in = bcd_pair(line_end.digits[4], line_end.digits[5]);
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_hour_out   = hour_ff;
   assign rsp_minute_out = minute_ff;
   assign rsp_second_out = second_ff;

endmodule

[rtl/nmea_rmc_checksum_time_extract.sv]
// top level of the nmea rmc checksum checker and local time extractor
// depends on nrmc_pkg, nrmc_parse, nrmc_out and the assertion macro header
`include "nmea_rmc_checksum_time_extract_defines.svh"

// Takes an NMEA text stream one byte (word) per cycle on the req_ channel and
// gives at most one rsp_ word per line. Only lines starting with "$GPRMC,"
// followed by six decimal time digits and a '*' qualify; their newline (byte 10)
// yields either rsp_status = 0 with the local time, hour = (hh + offset) mod 24,
// or rsp_status = 1 with all time fields zero when the xor of the bytes between
// '$' and '*' differs from the one or two hex digits after '*' (missing digits
// count as 0). Any other line is swallowed silently. Throughput is one word per
// cycle: the parser updates its line state while a byte sits in the input
// register, and a result moves to the output register when its newline leaves
// the input register; rsp_valid is the output register's valid flag. A
// stalled rsp_ side only holds up input when the next byte would produce
// another result. The zone offset is written through csr_write_enable /
// csr_write_data and resets to 8; write it only while the block is idle.
module nmea_rmc_checksum_time_extract (
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_in,
   // results
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status,
   output logic [4:0] rsp_hour_out,
   output logic [6:0] rsp_minute_out,
   output logic [6:0] rsp_second_out,
   // zone offset register
   input  logic       csr_write_enable,
   input  logic [4:0] csr_write_data
);
   import nrmc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic [4:0]   zone_ff, zone_in;
   logic         req_accept;
   logic         advance;
   logic         out_free;
   logic         out_load;
   line_end_type line_end;

   // the byte in the input register moves on unless it closes a line and the
   // output register is still holding a result nobody took
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid || rsp_ready;
   assign advance    = in_valid_ff && (!line_end.emit || out_free);
   assign out_load   = advance && line_end.emit;
   assign req_ready  = !in_valid_ff || advance;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      zone_in = csr_write_enable ? csr_write_data : zone_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         zone_ff     <= ZONE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         zone_ff     <= zone_in;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_byte_in;
      end
   end

   nrmc_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .byte_in  (in_byte_ff),
      .advance  (advance),
      .line_end (line_end)
   );

   nrmc_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (out_load),
      .line_end       (line_end),
      .zone_offset    (zone_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out)
   );

   // a new result never overwrites one still waiting
   `NRMC_ASSERT_NOW(a_no_overwrite, clock, reset, out_load, out_free, "result overwritten")
   // a byte that closes no line never stalls in the input register
   `NRMC_ASSERT_NEXT(a_plain_byte_moves, clock, reset, in_valid_ff && !line_end.emit && !req_accept, !in_valid_ff, "input byte stalled")
   // checksum errors carry an all-zero time
   `NRMC_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_status, rsp_hour_out == 5'd0 && rsp_minute_out == 7'd0 && rsp_second_out == 7'd0, "error result with time")
   // local hour always wrapped
   `NRMC_ASSERT_NOW(a_hour_range, clock, reset, rsp_valid && !rsp_status, rsp_hour_out < 5'd24, "hour out of range")

endmodule

[bench/tb_nmea_rmc_checksum_time_extract.sv]
// testbench for nmea_rmc_checksum_time_extract: rmc lines in, local time or checksum error out
// holds its own line parser and time predictor; needs nrmc_pkg and the block's rtl
`timescale 1ns / 100ps

package rmc_time_check_pkg;
   import nrmc_pkg::*;

   localparam logic [7:0]  CHAR_CR        = 8'h0D;
   localparam logic [55:0] RMC_HEAD       = "$GPRMC,";
   localparam logic        STATUS_OK      = 1'b0;
   localparam logic        STATUS_BAD_SUM = 1'b1;

   typedef struct packed {
      logic       status;
      logic [4:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
   } local_time_word_type;

   // 0..15 for a hex character, -1 otherwise
   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
      if (c >= CHAR_UC_A && c <= CHAR_UC_F) return c - CHAR_UC_A + 10;
      if (c >= CHAR_LC_A && c <= CHAR_LC_F) return c - CHAR_LC_A + 10;
      return -1;
   endfunction

   class rmc_local_time_board;
      phase_type           phase;
      int unsigned         head_pos;
      logic [7:0]          xor_sum;
      logic [3:0]          digs [6];
      int unsigned         digit_count;
      logic [7:0]          sent_sum;
      int unsigned         sum_digits;
      logic [4:0]          zone;
      local_time_word_type times_due [$];
      int unsigned         times_predicted;
      int unsigned         errors;

      function new();
         zone            = ZONE_RESET;
         times_predicted = 0;
         errors          = 0;
         clear_line();
      endfunction

      function void clear_line();
         phase       = PH_PREFIX;
         head_pos    = 0;
         xor_sum     = 8'h00;
         digit_count = 0;
         sent_sum    = 8'h00;
         sum_digits  = 0;
         foreach (digs[i]) digs[i] = 4'h0;
      endfunction

      function void set_zone(input logic [4:0] z);
         zone = z;
      endfunction

      // one accepted byte; a newline may add one expected time word
      function void take_byte(input logic [7:0] b);
         local_time_word_type t;
         int unsigned         hh;
         int                  v;
         if (b == CHAR_LF) begin
            if (phase == PH_HEX || phase == PH_TAIL) begin
               t = '0;
               if (xor_sum == sent_sum) begin
                  hh       = digs[0] * 10 + digs[1];
                  t.status = STATUS_OK;
                  t.hour   = 5'((hh + zone) % 24);
                  t.minute = 7'(digs[2] * 10 + digs[3]);
                  t.second = 7'(digs[4] * 10 + digs[5]);
               end else begin
                  t.status = STATUS_BAD_SUM;
               end
               times_due.push_back(t);
               times_predicted++;
            end
            clear_line();
            return;
         end
         case (phase)
            PH_PREFIX: begin
               if (head_pos > 6 || b != RMC_HEAD[8 * (6 - head_pos) +: 8]) begin
                  phase = PH_DISCARD;
               end else begin
                  if (head_pos != 0) xor_sum ^= b;
                  head_pos++;
                  if (head_pos == 7) phase = PH_TIME;
               end
            end
            PH_TIME: begin
               if (b < CHAR_ZERO || b > CHAR_NINE) begin
                  phase = PH_DISCARD;
               end else begin
                  xor_sum ^= b;
                  digs[digit_count] = 4'(b - CHAR_ZERO);
                  digit_count++;
                  if (digit_count == 6) phase = PH_BODY;
               end
            end
            PH_BODY: begin
               if (b == CHAR_STAR) phase = PH_HEX;
               else xor_sum ^= b;
            end
            PH_HEX: begin
               v = hex_digit_value(b);
               if (v >= 0 && sum_digits < 2) begin
                  sent_sum = {sent_sum[3:0], 4'(v)};
                  sum_digits++;
                  if (sum_digits == 2) phase = PH_TAIL;
               end else begin
                  phase = PH_TAIL;
               end
            end
            default: ;
         endcase
      endfunction

      function void match_time_word(input local_time_word_type got);
         local_time_word_type exp_t;
         if (times_due.size() == 0) begin
            $error("unexpected time word: status %0d hour %0d minute %0d second %0d",
                   got.status, got.hour, got.minute, got.second);
            errors++;
            return;
         end
         exp_t = times_due.pop_front();
         if (got.status !== exp_t.status) begin
            $error("status: expected %0d, got %0d", exp_t.status, got.status);
            errors++;
         end
         if (got.hour !== exp_t.hour) begin
            $error("hour_out: expected %0d, got %0d", exp_t.hour, got.hour);
            errors++;
         end
         if (got.minute !== exp_t.minute) begin
            $error("minute_out: expected %0d, got %0d", exp_t.minute, got.minute);
            errors++;
         end
         if (got.second !== exp_t.second) begin
            $error("second_out: expected %0d, got %0d", exp_t.second, got.second);
            errors++;
         end
      endfunction
   endclass

endpackage

module tb_nmea_rmc_checksum_time_extract;
   import nrmc_pkg::*;
   import rmc_time_check_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned TIMEOUT_NS    = 200_000;  // far above the length of a slow run
   localparam int unsigned HOLD_CYCLES   = 200;

   // shapes of generated lines
   typedef enum {
      LN_GOOD,           // qualifying line, matching two-digit checksum
      LN_BAD_SUM,        // qualifying line, wrong checksum
      LN_EMPTY_SUM_OK,   // no hex digits after '*', xor padded to zero
      LN_EMPTY_SUM_BAD,  // no hex digits after '*', xor nonzero
      LN_ONE_HEX,        // single hex digit after '*'
      LN_BAD_TIME,       // non-digit among the time characters
      LN_OTHER,          // prefix differs from "$GPRMC,"
      LN_NO_STAR,        // rmc line that never sends '*'
      LN_CUT,            // good line cut short by an early newline
      LN_NOISE           // random bytes then newline
   } line_kind_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_byte_in;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_status;
   logic [4:0] rsp_hour_out;
   logic [6:0] rsp_minute_out;
   logic [6:0] rsp_second_out;
   logic       csr_write_enable;
   logic [4:0] csr_write_data;

   rmc_local_time_board tracker;
   logic [7:0]  line_q [$];     // line being sent
   logic [7:0]  body_fill [$];  // fixed body for directed lines, random when empty
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned hold_left;

   nmea_rmc_checksum_time_extract i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- line building

   function automatic logic [7:0] any_but_lf();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CHAR_LF);
      return b;
   endfunction

   // body bytes must not end the line or open the checksum
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do b = any_but_lf(); while (b == CHAR_STAR);
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return CHAR_ZERO + 8'(v);
      return (lower ? CHAR_LC_A : CHAR_UC_A) + 8'(v) - 8'd10;
   endfunction

   // xor of everything after the '$' that is queued so far
   function automatic logic [7:0] line_xor();
      logic [7:0] x;
      x = 8'h00;
      for (int i = 1; i < line_q.size(); i++) x ^= line_q[i];
      return x;
   endfunction

   function automatic logic [23:0] random_time();
      logic [23:0] t;
      t = '0;
      repeat (6) t = {t[19:0], 4'($urandom_range(9))};
      return t;
   endfunction

   // variant: lower-case hex for checksum lines, '*' as the bad time
   // character, matching digit for the one-digit checksum
   task automatic make_line(input line_kind_type k, input logic [23:0] hhmmss,
                            input int unsigned body_len, input int unsigned tail_len,
                            input bit variant);
      logic [7:0]  sum;
      logic [7:0]  b;
      logic [3:0]  v;
      int unsigned spot;
      int unsigned cut;
      line_q.delete();
      if (k == LN_NOISE) begin
         repeat (body_len) line_q.push_back(any_but_lf());
         line_q.push_back(CHAR_LF);
         return;
      end
      for (int i = 0; i < 7; i++) line_q.push_back(RMC_HEAD[8 * (6 - i) +: 8]);
      for (int i = 0; i < 6; i++) line_q.push_back(CHAR_ZERO + 8'(hhmmss[4 * (5 - i) +: 4]));
      if (k == LN_OTHER) begin
         spot = $urandom_range(6);
         do b = any_but_lf(); while (b == line_q[spot]);
         line_q[spot] = b;
      end
      if (k == LN_BAD_TIME) begin
         spot = 7 + $urandom_range(5);
         if (variant) b = CHAR_STAR;
         else do b = any_but_lf(); while (b >= CHAR_ZERO && b <= CHAR_NINE);
         line_q[spot] = b;
      end
      if (body_fill.size() != 0) begin
         foreach (body_fill[i]) line_q.push_back(body_fill[i]);
         body_fill.delete();
      end else begin
         repeat (body_len) line_q.push_back(body_byte());
      end
      if (k == LN_NO_STAR) begin
         line_q.push_back(CHAR_LF);
         return;
      end
      sum = line_xor();
      case (k)
         LN_EMPTY_SUM_OK: begin
            // an empty checksum reads as zero, so bring the xor to zero
            if (sum == CHAR_LF || sum == CHAR_STAR) begin
               line_q.push_back(8'h01);
               sum ^= 8'h01;
            end
            if (sum != 8'h00) line_q.push_back(sum);
            line_q.push_back(CHAR_STAR);
         end
         LN_EMPTY_SUM_BAD: begin
            if (sum == 8'h00) line_q.push_back(8'h01);
            line_q.push_back(CHAR_STAR);
         end
         LN_ONE_HEX: begin
            // pad so the xor equals a single nibble
            do v = 4'($urandom_range(15));
            while ((sum ^ {4'h0, v}) == CHAR_LF || (sum ^ {4'h0, v}) == CHAR_STAR);
            line_q.push_back(sum ^ {4'h0, v});
            line_q.push_back(CHAR_STAR);
            line_q.push_back(hex_char(variant ? v : v ^ 4'h1, 1'($urandom_range(1))));
         end
         LN_BAD_SUM: begin
            sum ^= 8'($urandom_range(1, 255));
            line_q.push_back(CHAR_STAR);
            line_q.push_back(hex_char(sum[7:4], variant));
            line_q.push_back(hex_char(sum[3:0], variant));
         end
         default: begin
            line_q.push_back(CHAR_STAR);
            line_q.push_back(hex_char(sum[7:4], variant));
            line_q.push_back(hex_char(sum[3:0], variant));
         end
      endcase
      // tail; after a short checksum the first tail byte must not read as hex
      for (int i = 0; i < tail_len; i++) begin
         if (i == 0 && $urandom_range(1)) begin
            b = CHAR_CR;
         end else if (i == 0 && (k == LN_EMPTY_SUM_OK || k == LN_EMPTY_SUM_BAD ||
                                 k == LN_ONE_HEX)) begin
            do b = any_but_lf(); while (hex_digit_value(b) >= 0);
         end else begin
            b = any_but_lf();
         end
         line_q.push_back(b);
      end
      if (k == LN_CUT) begin
         cut = $urandom_range(1, line_q.size() - 1);
         while (line_q.size() > cut) void'(line_q.pop_back());
      end
      line_q.push_back(CHAR_LF);
   endtask

   // ---------------------------------------------------------------- driving

   // valid stays up across back-to-back words; it only drops on an idle cycle
   task automatic send_word(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_byte(b);
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_word(line_q[i]);
   endtask

   // block idle: nothing owed, then a wait of SETTLE_CYCLES for lines that give no word
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (tracker.times_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_zone(input logic [4:0] z);
      csr_write_enable <= 1'b1;
      csr_write_data   <= z;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_zone(z);
   endtask

   // mostly well-formed rmc lines with random content, some broken ones and noise;
   // only bytes of qualifying lines count toward the word goal
   task automatic run_random(input int unsigned word_goal, input int unsigned time_goal);
      int unsigned   useful;
      int unsigned   times0;
      int unsigned   pick;
      int unsigned   body_len;
      line_kind_type k;
      useful = 0;
      times0 = tracker.times_predicted;
      while (useful < word_goal || tracker.times_predicted - times0 < time_goal) begin
         pick = $urandom_range(99);
         if      (pick < 45) k = LN_GOOD;
         else if (pick < 55) k = LN_BAD_SUM;
         else if (pick < 61) k = LN_EMPTY_SUM_OK;
         else if (pick < 65) k = LN_EMPTY_SUM_BAD;
         else if (pick < 72) k = LN_ONE_HEX;
         else if (pick < 78) k = LN_BAD_TIME;
         else if (pick < 83) k = LN_OTHER;
         else if (pick < 88) k = LN_NO_STAR;
         else if (pick < 95) k = LN_CUT;
         else                k = LN_NOISE;
         // mostly short bodies, now and then a long one
         body_len = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
         make_line(k, random_time(), body_len, $urandom_range(0, 3), 1'($urandom_range(1)));
         if (k inside {LN_GOOD, LN_BAD_SUM, LN_EMPTY_SUM_OK, LN_EMPTY_SUM_BAD, LN_ONE_HEX})
            useful += line_q.size();
         send_line();
      end
   endtask

   // ---------------------------------------------------------------- result side

   // checks every accepted time word; stalls at random or for a counted hold-off
   initial begin
      local_time_word_type got;
      rsp_ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.hour   = rsp_hour_out;
            got.minute = rsp_minute_out;
            got.second = rsp_second_out;
            tracker.match_time_word(got);
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      tracker          = new();
      send_idle_pct    = 0;
      stall_pct        = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_byte_in      <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 5'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed lines at the reset zone offset, no idling
      make_line(LN_GOOD, 24'h235959, 0, 0, 1'b0);          // hour wraps past midnight
      send_line();
      body_fill = {8'h00, 8'hFF, 8'h2C, CHAR_CR};           // byte extremes in the body
      make_line(LN_GOOD, 24'h000000, 0, 1, 1'b1);           // lower-case checksum
      send_line();
      make_line(LN_GOOD, 24'h999999, 2, 0, 1'b0);
      line_q.insert(line_q.size() - 1, CHAR_UC_F);          // third hex digit is ignored
      line_q.insert(line_q.size() - 1, CHAR_STAR);          // later star is ignored
      send_line();
      make_line(LN_BAD_SUM, 24'h123456, 3, 1, 1'b0);
      send_line();
      make_line(LN_EMPTY_SUM_OK, 24'h075930, 2, 0, 1'b0);   // star then newline, xor zero
      send_line();
      make_line(LN_EMPTY_SUM_BAD, 24'h180000, 2, 2, 1'b0);
      send_line();
      make_line(LN_ONE_HEX, 24'h010203, 1, 1, 1'b1);
      send_line();
      make_line(LN_BAD_TIME, 24'h121212, 2, 0, 1'b1);       // star inside the time
      send_line();
      make_line(LN_BAD_TIME, 24'h121212, 2, 0, 1'b0);
      send_line();
      make_line(LN_OTHER, 24'h101010, 2, 0, 1'b0);
      send_line();
      make_line(LN_NO_STAR, 24'h111111, 3, 0, 1'b0);
      send_line();
      make_line(LN_NOISE, 24'h000000, 0, 0, 1'b0);          // empty line
      send_line();
      make_line(LN_CUT, 24'h220000, 2, 1, 1'b0);
      send_line();
      make_line(LN_GOOD, 24'h205959, 60, 1, 1'b1);          // long line
      send_line();

      // random phases, each at its own zone offset and idling pattern
      wait_drain();
      write_zone(5'd0);
      run_random(40, 3);

      wait_drain();
      write_zone(5'd23);
      send_idle_pct = 51;
      run_random(40, 3);

      wait_drain();
      write_zone(5'd31);                                    // above 23 still wraps
      send_idle_pct = 0;
      stall_pct     = 51;
      run_random(40, 3);

      wait_drain();
      write_zone(5'($urandom_range(31)));
      send_idle_pct = 10;
      stall_pct     = 10;
      run_random(40, 3);

      // result side held off while good lines keep coming, so the input backs up
      wait_drain();
      write_zone(5'($urandom_range(31)));
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = HOLD_CYCLES;
      repeat (8) begin
         make_line(LN_GOOD, random_time(), $urandom_range(0, 3), 0, 1'($urandom_range(1)));
         send_line();
      end

      wait_drain();
      if (tracker.errors == 0 && tracker.times_due.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // hung handshake guard
   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[nmea_rmc_checksum_time_extract.f]
+incdir+rtl
rtl/nrmc_pkg.sv
rtl/nrmc_parse.sv
rtl/nrmc_out.sv
rtl/nmea_rmc_checksum_time_extract.sv
bench/tb_nmea_rmc_checksum_time_extract.sv
